[rtl/base64_stream_decoder_macros.svh]
// assertion macros for the base64 stream decoder
// used by the modules that carry concurrent checks; depends on nothing
`ifndef BASE64_STREAM_DECODER_MACROS_SVH
`define BASE64_STREAM_DECODER_MACROS_SVH

// same-cycle implication, disabled in reset
`define B64SD_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("b64sd check failed");

// next-cycle implication, disabled in reset
`define B64SD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("b64sd check failed");

`endif

[rtl/b64sd_pkg.sv]
// shared types and constants of the base64 stream decoder
// used by every module of the block; depends on nothing
package b64sd_pkg;

    localparam int CHAR_W          = 8;
    localparam int BYTE_W          = 8;
    localparam int SYM_W           = 6;
    localparam int ACC_W           = 12;
    localparam int PEND_W          = 3;
    localparam int CAP_W           = 16;
    localparam int STATUS_W        = 2;
    localparam int COUNT_OUT_W     = 16;
    localparam int COUNT_WIDTH_DEF = 16;
    localparam int S_TDATA_W       = 8;
    localparam int M_TDATA_W       = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = 16'hFFFF;

    localparam logic [STATUS_W-1:0] STATUS_BUSY  = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_DIGIT_0 = 8'h30;
    localparam logic [CHAR_W-1:0] CH_DIGIT_9 = 8'h39;
    localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_PAD     = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LF      = 8'h0A;

    localparam logic [SYM_W-1:0] LOWER_BASE = 6'd26;
    localparam logic [SYM_W-1:0] DIGIT_BASE = 6'd52;
    localparam logic [SYM_W-1:0] SYM_PLUS   = 6'd62;
    localparam logic [SYM_W-1:0] SYM_SLASH  = 6'd63;

    typedef enum logic [1:0] {
        SYM_DATA = 2'd0,
        SYM_SKIP = 2'd1,
        SYM_PAD  = 2'd2,
        SYM_BAD  = 2'd3
    } sym_kind_t;

    typedef struct packed {
        sym_kind_t        kind;
        logic [SYM_W-1:0] value;
    } sym_t;

    typedef enum logic [2:0] {
        MODE_DECODING = 3'b001,
        MODE_ENDED    = 3'b010,
        MODE_ERROR    = 3'b100
    } mode_t;

endpackage

[rtl/base64_stream_decoder.sv]
// channel     | dir | signals                    | content
// s_ (char)   | in  | s_tvalid s_tready s_tdata  | char_in, last_char on s_tlast
// m_ (result) | out | m_tvalid m_tready m_tdata  | out_byte, status, byte_count;
//             |     | m_tuser                    | byte_valid
// cfg         | in  | cfg_we cfg_wdata           | output_capacity
// one character per cycle sustained while m_ is not stalled; an s_ beat reaches m_ through
// the input register and then the result register around the decode logic
// aresetn is synchronous: clears the decode state, sets capacity to 65535
// input register and result register let s_ take a beat while m_ is stalled;
// s_tready drops only when both hold a beat
// top level of the base64 stream decoder
// depends on b64sd_pkg and b64sd_core
module base64_stream_decoder #(
    parameter int COUNT_WIDTH = b64sd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [b64sd_pkg::S_TDATA_W-1:0] s_tdata,   // [7:0] char_in
    input  logic                            s_tlast,   // last_char
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [b64sd_pkg::M_TDATA_W-1:0] m_tdata,   // [7:0] out_byte, [9:8] status,
                                                       // [25:10] byte_count, [31:26] zero
    output logic                            m_tuser,   // byte_valid
    input  logic                            cfg_we,
    input  logic [b64sd_pkg::CAP_W-1:0]     cfg_wdata  // output_capacity
);
    import b64sd_pkg::*;

    logic                in_valid_reg, in_valid_next;
    logic [CHAR_W-1:0]   in_char_reg;
    logic                in_last_reg;
    logic [CAP_W-1:0]    cap_reg;
    logic                core_ready;
    logic [BYTE_W-1:0]   res_byte;
    logic                res_bvalid;
    logic [STATUS_W-1:0] res_status;
    logic [COUNT_OUT_W-1:0] res_count;

    assign s_tready = !in_valid_reg || core_ready;

    always_comb begin
        if (s_tvalid && s_tready) begin
            in_valid_next = 1'b1;
        end else if (core_ready) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cap_reg      <= CAP_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_char_reg <= s_tdata[CHAR_W-1:0];
            in_last_reg <= s_tlast;
        end
    end

    b64sd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (in_valid_reg),
        .in_char        (in_char_reg),
        .in_last        (in_last_reg),
        .in_ready       (core_ready),
        .capacity       (cap_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_byte       (res_byte),
        .out_byte_valid (res_bvalid),
        .out_status     (res_status),
        .out_count      (res_count)
    );

    assign m_tdata = M_TDATA_W'({res_count, res_status, res_byte});
    assign m_tuser = res_bvalid;

endmodule

[rtl/b64sd_char_map.sv]
// character classifier: maps one input character to a 6-bit symbol or a kind
// depends on b64sd_pkg
module b64sd_char_map (
    input  logic [b64sd_pkg::CHAR_W-1:0] char_in,
    output b64sd_pkg::sym_t              sym
);
    import b64sd_pkg::*;

    always_comb begin
        sym.kind  = SYM_BAD;
        sym.value = '0;
        if (char_in >= CH_UPPER_A && char_in <= CH_UPPER_Z) begin
            sym.kind  = SYM_DATA;
            sym.value = SYM_W'(char_in - CH_UPPER_A);
        end else if (char_in >= CH_LOWER_A && char_in <= CH_LOWER_Z) begin
            sym.kind  = SYM_DATA;
            sym.value = SYM_W'(char_in - CH_LOWER_A) + LOWER_BASE;
        end else if (char_in >= CH_DIGIT_0 && char_in <= CH_DIGIT_9) begin
            sym.kind  = SYM_DATA;
            sym.value = SYM_W'(char_in - CH_DIGIT_0) + DIGIT_BASE;
        end else if (char_in == CH_PLUS) begin
            sym.kind  = SYM_DATA;
            sym.value = SYM_PLUS;
        end else if (char_in == CH_SLASH) begin
            sym.kind  = SYM_DATA;
            sym.value = SYM_SLASH;
        end else if (char_in == CH_PAD) begin
            sym.kind  = SYM_PAD;
        end else if (char_in == CH_SPACE || char_in == CH_TAB ||
                     char_in == CH_CR || char_in == CH_LF) begin
            sym.kind  = SYM_SKIP;
        end
    end

endmodule

[rtl/b64sd_core.sv]
// decode state, per-character update and result register
// depends on b64sd_pkg, b64sd_char_map and the assertion macro header
`include "base64_stream_decoder_macros.svh"

module b64sd_core #(
    parameter int COUNT_WIDTH = b64sd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  logic [b64sd_pkg::CHAR_W-1:0]      in_char,
    input  logic                              in_last,
    output logic                              in_ready,
    input  logic [b64sd_pkg::CAP_W-1:0]       capacity,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [b64sd_pkg::BYTE_W-1:0]      out_byte,
    output logic                              out_byte_valid,
    output logic [b64sd_pkg::STATUS_W-1:0]    out_status,
    output logic [b64sd_pkg::COUNT_OUT_W-1:0] out_count
);
    import b64sd_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W;

    logic [ACC_W-1:0]       acc_reg, acc_next;
    logic [PEND_W-1:0]      pend_reg, pend_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    mode_t                  mode_reg, mode_next;

    logic                   out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0]      byte_reg, byte_next;
    logic                   bvalid_reg, bvalid_next;
    logic [STATUS_W-1:0]    status_reg, status_next;
    logic [COUNT_OUT_W-1:0] ocount_reg, ocount_next;

    sym_t                   sym;
    logic                   advance;
    logic                   full;
    logic [ACC_W-1:0]       acc_shift;
    logic [PEND_W:0]        pend_sum;
    logic [PEND_W:0]        pend_after;
    logic [ACC_W-1:0]       acc_upd;
    logic [PEND_W-1:0]      pend_upd;
    logic [COUNT_WIDTH-1:0] count_upd;
    mode_t                  mode_upd;

    b64sd_char_map u_char_map (
        .char_in (in_char),
        .sym     (sym)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign advance  = in_valid && in_ready;

    assign full = (CMP_W'(count_reg) >= CMP_W'(capacity)) || (count_reg == '1);
    assign acc_shift  = {acc_reg[ACC_W-SYM_W-1:0], sym.value};
    assign pend_sum   = {1'b0, pend_reg} + (PEND_W+1)'(SYM_W);
    assign pend_after = pend_sum - (PEND_W+1)'(BYTE_W);

    always_comb begin
        acc_upd     = acc_reg;
        pend_upd    = pend_reg;
        count_upd   = count_reg;
        mode_upd    = mode_reg;
        byte_next   = '0;
        bvalid_next = 1'b0;
        if (mode_reg == MODE_DECODING) begin
            case (sym.kind)
                SYM_PAD: begin
                    mode_upd = MODE_ENDED;
                end
                SYM_BAD: begin
                    mode_upd = MODE_ERROR;
                end
                SYM_DATA: begin
                    acc_upd = acc_shift;
                    if (pend_sum >= (PEND_W+1)'(BYTE_W)) begin
                        pend_upd = PEND_W'(pend_after);
                        if (full) begin
                            mode_upd = MODE_ERROR;
                        end else begin
                            bvalid_next = 1'b1;
                            count_upd   = count_reg + 1'b1;
                            case (pend_after[PEND_W-1:0])
                                3'd2:    byte_next = acc_shift[9:2];
                                3'd4:    byte_next = acc_shift[11:4];
                                default: byte_next = acc_shift[7:0];
                            endcase
                        end
                    end else begin
                        pend_upd = PEND_W'(pend_sum);
                    end
                end
                default: begin
                end
            endcase
        end

        status_next = STATUS_BUSY;
        if (in_last) begin
            status_next = (mode_upd == MODE_ERROR) ? STATUS_ERROR : STATUS_OK;
        end
        ocount_next = COUNT_OUT_W'(count_upd);

        if (in_last) begin
            acc_next   = '0;
            pend_next  = '0;
            count_next = '0;
            mode_next  = MODE_DECODING;
        end else begin
            acc_next   = acc_upd;
            pend_next  = pend_upd;
            count_next = count_upd;
            mode_next  = mode_upd;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (out_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            pend_reg      <= '0;
            count_reg     <= '0;
            mode_reg      <= MODE_DECODING;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (advance) begin
                acc_reg   <= acc_next;
                pend_reg  <= pend_next;
                count_reg <= count_next;
                mode_reg  <= mode_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            byte_reg   <= byte_next;
            bvalid_reg <= bvalid_next;
            status_reg <= status_next;
            ocount_reg <= ocount_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_byte       = byte_reg;
    assign out_byte_valid = bvalid_reg;
    assign out_status     = status_reg;
    assign out_count      = ocount_reg;

    // end of message leaves a clean state
    `B64SD_ASSERT_NEXT(a_last_clears, aclk, aresetn, advance && in_last,
        count_reg == '0 && pend_reg == '0 && mode_reg == MODE_DECODING)
    // pending bits stay even
    `B64SD_ASSERT_IMPL(a_pend_even, aclk, aresetn, 1'b1, pend_reg[0] == 1'b0)
    // an emitted byte bumps the counter by one
    `B64SD_ASSERT_NEXT(a_count_step, aclk, aresetn, advance && bvalid_next && !in_last,
        count_reg == COUNT_WIDTH'($past(count_reg) + 1'b1))
    // no byte once decoding has stopped
    `B64SD_ASSERT_IMPL(a_no_byte_stopped, aclk, aresetn, mode_reg != MODE_DECODING,
        bvalid_next == 1'b0)

endmodule

[dv/base64_stream_decoder_checker.sv]
// result checker for the base64 stream decoder: predicts every result beat from
// the accepted character beats and register writes, and compares field by field
// depends on b64sd_pkg
module base64_stream_decoder_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [b64sd_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                            s_tlast,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [b64sd_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                            m_tuser,
    input  logic                            cfg_we,
    input  logic [b64sd_pkg::CAP_W-1:0]     cfg_wdata,
    output int                              fail_count,
    output int                              beats_owed,
    output int                              msg_count,
    output int                              byte_total,
    output int                              error_msgs
);
    import b64sd_pkg::*;

    localparam logic [COUNT_WIDTH_DEF:0] COUNT_MAX =
        (COUNT_WIDTH_DEF+1)'((1 << COUNT_WIDTH_DEF) - 1);

    typedef struct packed {
        logic [BYTE_W-1:0]      out_byte;
        logic                   byte_valid;
        logic [STATUS_W-1:0]    status;
        logic [COUNT_OUT_W-1:0] byte_count;
    } decode_result_t;

    decode_result_t         decoded_q[$];
    logic [CAP_W-1:0]       capacity;
    logic [ACC_W-1:0]       acc;
    logic [PEND_W-1:0]      acc_bits;
    logic [COUNT_WIDTH_DEF:0] byte_cnt;
    mode_t                  mode;
    int                     n_fail  = 0;
    int                     n_msgs  = 0;
    int                     n_bytes = 0;
    int                     n_err   = 0;

    assign fail_count = n_fail;
    assign msg_count  = n_msgs;
    assign byte_total = n_bytes;
    assign error_msgs = n_err;

    function automatic sym_t classify(input logic [CHAR_W-1:0] c);
        sym_t s;
        s.kind  = SYM_DATA;
        s.value = '0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            s.value = SYM_W'(c - CH_UPPER_A);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            s.value = SYM_W'(c - CH_LOWER_A) + LOWER_BASE;
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            s.value = SYM_W'(c - CH_DIGIT_0) + DIGIT_BASE;
        end else if (c == CH_PLUS) begin
            s.value = SYM_PLUS;
        end else if (c == CH_SLASH) begin
            s.value = SYM_SLASH;
        end else if (c == CH_PAD) begin
            s.kind = SYM_PAD;
        end else if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
            s.kind = SYM_SKIP;
        end else begin
            s.kind = SYM_BAD;
        end
        return s;
    endfunction

    task automatic clear_message();
        acc      = '0;
        acc_bits = '0;
        byte_cnt = '0;
        mode     = MODE_DECODING;
    endtask

    task automatic decode_char(input logic [CHAR_W-1:0] c, input logic last,
                               output decode_result_t r);
        sym_t            s;
        logic [PEND_W:0] bits;
        r = '0;
        if (mode == MODE_DECODING) begin
            s = classify(c);
            case (s.kind)
                SYM_PAD: mode = MODE_ENDED;
                SYM_BAD: mode = MODE_ERROR;
                SYM_DATA: begin
                    acc  = {acc[ACC_W-SYM_W-1:0], s.value};
                    bits = {1'b0, acc_bits} + (PEND_W+1)'(SYM_W);
                    if (bits >= (PEND_W+1)'(BYTE_W)) begin
                        bits = bits - (PEND_W+1)'(BYTE_W);
                        // capacity reached, or the counter would overflow
                        if (byte_cnt >= {1'b0, capacity} || byte_cnt >= COUNT_MAX) begin
                            mode = MODE_ERROR;
                        end else begin
                            r.out_byte   = BYTE_W'(acc >> bits);
                            r.byte_valid = 1'b1;
                            byte_cnt     = byte_cnt + 1'b1;
                        end
                    end
                    acc_bits = bits[PEND_W-1:0];
                end
                default: ;
            endcase
        end
        if (last) begin
            r.status = (mode == MODE_ERROR) ? STATUS_ERROR : STATUS_OK;
        end else begin
            r.status = STATUS_BUSY;
        end
        r.byte_count = byte_cnt[COUNT_OUT_W-1:0];
        if (last) begin
            clear_message();
        end
    endtask

    always @(posedge aclk) begin
        decode_result_t want;
        decode_result_t got;
        decode_result_t fresh;
        if (!aresetn) begin
            capacity = CAP_RESET;
            clear_message();
            decoded_q.delete();
        end else begin
            if (cfg_we) begin
                capacity = cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                got = '{out_byte: m_tdata[7:0], byte_valid: m_tuser,
                        status: m_tdata[9:8], byte_count: m_tdata[25:10]};
                if (decoded_q.size() == 0) begin
                    n_fail++;
                    if (n_fail <= 10) begin
                        $display("%0t: result beat with nothing expected: tdata %h tuser %b",
                                 $time, m_tdata, m_tuser);
                    end
                end else begin
                    want = decoded_q.pop_front();
                    if (got !== want || m_tdata[31:26] !== '0) begin
                        n_fail++;
                        if (n_fail <= 10) begin
                            $display({"%0t: expected byte %h valid %b status %0d count %0d,",
                                      " got byte %h valid %b status %0d count %0d pad %h"},
                                     $time, want.out_byte, want.byte_valid, want.status,
                                     want.byte_count, got.out_byte, got.byte_valid,
                                     got.status, got.byte_count, m_tdata[31:26]);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                decode_char(s_tdata, s_tlast, fresh);
                decoded_q.push_back(fresh);
                n_bytes += fresh.byte_valid;
                if (s_tlast) begin
                    n_msgs++;
                    if (fresh.status == STATUS_ERROR) begin
                        n_err++;
                    end
                end
            end
        end
        beats_owed <= decoded_q.size();
    end

endmodule

[dv/tb_base64_stream_decoder.sv]
// testbench top for the base64 stream decoder: drives character beats, result
// back-pressure and capacity writes, and gives the verdict
// depends on b64sd_pkg, base64_stream_decoder and base64_stream_decoder_checker
module tb_base64_stream_decoder;
    import b64sd_pkg::*;

    localparam int RANDOM_CHARS = 1500;
    localparam int LONG_CHARS   = 100;
    localparam int HOLD_CYCLES  = 60;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    logic                 s_tlast   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 cfg_we    = 1'b0;
    logic [CAP_W-1:0]     cfg_wdata = '0;

    int    fail_count;
    int    beats_owed;
    int    msg_count;
    int    byte_total;
    int    error_msgs;
    int    chars_sent = 0;
    bit    gaps_on    = 1'b1;
    bit    hold_req   = 1'b0;
    string alphabet   = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    always #4 aclk = ~aclk;

    base64_stream_decoder i_dut (.*);

    base64_stream_decoder_checker i_checker (.*);

    function automatic logic [CHAR_W-1:0] data_char();
        return alphabet[$urandom_range(63)];
    endfunction

    function automatic logic [CHAR_W-1:0] blank_char();
        case ($urandom_range(3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    task automatic send_char(input logic [CHAR_W-1:0] c, input logic last);
        while (gaps_on && $urandom_range(99) < 12) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        chars_sent++;
    endtask

    task automatic send_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            send_char(t[i], i == t.len() - 1);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (beats_owed != 0);
    endtask

    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    // mostly well-formed messages, some with a stray byte, some pure noise
    task automatic send_random_message(input int max_len);
        logic [CHAR_W-1:0] msg[$];
        int                shape;
        int                len;
        shape = $urandom_range(99);
        len   = $urandom_range(1, max_len);
        for (int i = 0; i < len; i++) begin
            msg.push_back(($urandom_range(9) == 0) ? blank_char() : data_char());
        end
        if (shape < 70) begin
            repeat ($urandom_range(2)) msg.push_back(CH_PAD);
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 3)) msg.push_back(CHAR_W'($urandom()));
            end
        end else if (shape < 88) begin
            msg.insert($urandom_range(msg.size()), CHAR_W'($urandom()));
        end else begin
            foreach (msg[i]) msg[i] = CHAR_W'($urandom());
        end
        foreach (msg[i]) send_char(msg[i], i == msg.size() - 1);
    endtask

    // result side back-pressure, with one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_req = 1'b0;
            end
            m_tready <= !(gaps_on && $urandom_range(99) < 12);
        end
    end

    initial begin
        logic [CAP_W-1:0] caps[5];
        int               base;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: whole group, every skip char, pad, bad chars, capacity edges
        send_text("TWFu");
        send_text("Z a\t9\r+\n/=");
        send_text("@A");
        send_char(8'hFF, 1'b1);
        send_text("Q=x");
        set_capacity(16'd0);
        send_text("QQ");
        set_capacity(16'd1);
        send_text("QUJD");

        caps = '{CAP_RESET, 16'd0, 16'($urandom()), 16'd3, 16'($urandom_range(1, 12))};
        base = chars_sent;
        for (int p = 0; p < 5; p++) begin
            set_capacity(caps[p]);
            gaps_on = (p != 2);
            if (p == 1) begin
                hold_req = 1'b1;
            end
            while (chars_sent < base + (p + 1) * RANDOM_CHARS / 5) begin
                send_random_message(24);
            end
        end

        // one long message at full capacity
        gaps_on = 1'b1;
        set_capacity(CAP_RESET);
        for (int i = 0; i < LONG_CHARS; i++) begin
            send_char(data_char(), i == LONG_CHARS - 1);
        end

        drain();
        repeat (4) @(posedge aclk);
        $display("sent %0d characters in %0d messages: %0d bytes decoded, %0d messages in error",
                 chars_sent, msg_count, byte_total, error_msgs);
        $display("capacities 0, 1, 3, small, random and 65535, plus one long message");
        if (fail_count == 0) begin
            $display("base64_stream_decoder: match");
        end else begin
            $display("base64_stream_decoder: mismatch");
        end
        $finish;
    end

    initial begin
        #(8 * 4_000_000);
        $display("timeout with %0d result beats outstanding", beats_owed);
        $display("base64_stream_decoder: mismatch");
        $finish;
    end

endmodule
